### rtl/core/fbpa_pkg.sv
// shared types, codes and constants of the fixed block pool allocator
`default_nettype none

package fbpa_pkg;

  // field widths
  localparam int ADDR_W    = 32;
  localparam int SIZE_W    = 13;
  localparam int CNT_W     = 11;
  localparam int REQ_W     = 16;
  localparam int OP_W      = 3;
  localparam int ALIGN_W   = 3;
  localparam int ORIG_W    = 6;
  localparam int STATUS_W  = 3;
  localparam int CLASS_W   = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // stream widths
  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 72;

  // operations
  localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
  localparam logic [OP_W-1:0] OP_FREE    = 3'd1;
  localparam logic [OP_W-1:0] OP_REALLOC = 3'd2;
  localparam logic [OP_W-1:0] OP_SET     = 3'd3;
  localparam logic [OP_W-1:0] OP_GET     = 3'd4;
  localparam logic [OP_W-1:0] OP_REINIT  = 3'd5;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_ADDR  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_ALIGN = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ARENA_BASE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_COUNT = 2'd2;

  // reset values and limits
  localparam logic [ADDR_W-1:0]  RST_ARENA_BASE    = 32'd0;
  localparam logic [SIZE_W-1:0]  RST_ELEMENT_SIZE  = 13'd16;
  localparam logic [CNT_W-1:0]   RST_ELEMENT_COUNT = 11'd1024;
  localparam logic [SIZE_W-1:0]  MIN_ELEMENT_SIZE  = 13'd4;
  localparam logic [CNT_W-1:0]   COUNT_MAX         = 11'd2047;
  localparam logic [ALIGN_W-1:0] ALIGN_MAX         = 3'd2;

  // size class codes
  localparam logic [CLASS_W-1:0] CLASS_NONE = 3'd0;
  localparam logic [CLASS_W-1:0] CLASS_4    = 3'd1;
  localparam logic [CLASS_W-1:0] CLASS_8    = 3'd2;
  localparam logic [CLASS_W-1:0] CLASS_32   = 3'd3;
  localparam logic [CLASS_W-1:0] CLASS_48   = 3'd4;

  function automatic logic [CLASS_W-1:0] encode_class(input logic [REQ_W-1:0] size);
    logic [CLASS_W-1:0] code;
    if (size <= 16'd4) begin
      code = CLASS_4;
    end else if (size <= 16'd8) begin
      code = CLASS_8;
    end else if (size <= 16'd32) begin
      code = CLASS_32;
    end else if (size <= 16'd48) begin
      code = CLASS_48;
    end else begin
      code = CLASS_NONE;
    end
    return code;
  endfunction

  function automatic logic [ORIG_W-1:0] decode_class(input logic [CLASS_W-1:0] code);
    logic [ORIG_W-1:0] size;
    unique case (code)
      CLASS_4:  size = 6'd4;
      CLASS_8:  size = 6'd8;
      CLASS_32: size = 6'd32;
      CLASS_48: size = 6'd48;
      default:  size = 6'd0;
    endcase
    return size;
  endfunction

  // controller to datapath
  typedef struct packed {
    logic                load_in;
    logic                sweep_init;
    logic                sweep_step;
    logic                div_start;
    logic                link_rd;
    logic                mul;
    logic                pop;
    logic                push;
    logic                class_wr;
    logic                class_rd;
    logic                set_orig;
    logic                set_status;
    logic [STATUS_W-1:0] status_code;
    logic                set_null;
    logic                set_realloc;
    logic                emit;
  } fbpa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic            align_bad;
    logic            head_null;
    logic            oversize;
    logic            sweep_last;
    logic            div_done;
    logic            addr_bad;
    logic            out_free;
    logic [OP_W-1:0] op;
  } fbpa_sts_t;

endpackage

`default_nettype wire

### rtl/core/fbpa_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/fbpa_div.sv
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module fbpa_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [fbpa_pkg::ADDR_W-1:0] dividend,
  input  wire logic [fbpa_pkg::SIZE_W-1:0] divisor,
  output      logic                        done,
  output      logic [fbpa_pkg::ADDR_W-1:0] quotient,
  output      logic [fbpa_pkg::SIZE_W-1:0] remainder
);

  localparam int ADDR_W = fbpa_pkg::ADDR_W;
  localparam int SIZE_W = fbpa_pkg::SIZE_W;
  localparam int STEP_W = $clog2(ADDR_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [ADDR_W-1:0] quo;
  logic [SIZE_W-1:0] rem;
  logic [SIZE_W-1:0] dsor;
  logic [SIZE_W:0]   trial;
  logic [SIZE_W:0]   diff;
  logic              fits;

  // shift in the next dividend bit and try the subtraction
  assign trial = {rem, quo[ADDR_W-1]};
  assign fits  = trial >= {1'b0, dsor};
  assign diff  = trial - {1'b0, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
      quo  <= dividend;
      rem  <= '0;
      dsor <= divisor;
    end else if (busy) begin
      quo  <= {quo[ADDR_W-2:0], fits};
      rem  <= fits ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
      step <= step + STEP_W'(1);
      if (step == STEP_W'(ADDR_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

### rtl/core/fbpa_datapath.sv
// allocator datapath: config, free list, size classes, divider and output register
`default_nettype none

module fbpa_datapath #(
  parameter int MAX_BLOCKS = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fbpa_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic [fbpa_pkg::OP_W-1:0]        in_op,
  input  wire logic [fbpa_pkg::ADDR_W-1:0]      in_addr,
  input  wire logic [fbpa_pkg::REQ_W-1:0]       in_req,
  input  wire logic [fbpa_pkg::ALIGN_W-1:0]     in_align,
  input  wire logic                             out_ready,
  input  wire fbpa_pkg::fbpa_cmd_t              cmd,
  output      fbpa_pkg::fbpa_sts_t              sts,
  output      logic                             out_valid,
  output      logic [fbpa_pkg::ADDR_W-1:0]      out_addr,
  output      logic                             out_null,
  output      logic [fbpa_pkg::ORIG_W-1:0]      out_orig,
  output      logic [fbpa_pkg::STATUS_W-1:0]    out_status,
  output      logic [fbpa_pkg::CNT_W-1:0]       out_count,
  output      logic [fbpa_pkg::SIZE_W-1:0]      out_bsize
);

  localparam int ADDR_W   = fbpa_pkg::ADDR_W;
  localparam int SIZE_W   = fbpa_pkg::SIZE_W;
  localparam int CNT_W    = fbpa_pkg::CNT_W;
  localparam int REQ_W    = fbpa_pkg::REQ_W;
  localparam int OP_W     = fbpa_pkg::OP_W;
  localparam int ALIGN_W  = fbpa_pkg::ALIGN_W;
  localparam int ORIG_W   = fbpa_pkg::ORIG_W;
  localparam int STATUS_W = fbpa_pkg::STATUS_W;
  localparam int CLASS_W  = fbpa_pkg::CLASS_W;
  localparam int IDX_W    = $clog2(MAX_BLOCKS);
  localparam int LINK_W   = IDX_W + 1;
  localparam int PROD_W   = IDX_W + SIZE_W;

  localparam logic [LINK_W-1:0] LINK_NULL = {1'b1, {IDX_W{1'b0}}};
  localparam logic [CNT_W-1:0] RST_EFF_COUNT =
    (int'(fbpa_pkg::RST_ELEMENT_COUNT) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS)
                                                     : fbpa_pkg::RST_ELEMENT_COUNT;

  // configuration
  logic [ADDR_W-1:0] arena_base;
  logic [SIZE_W-1:0] element_size;
  logic [CNT_W-1:0]  element_count;
  logic [SIZE_W-1:0] eff_size;
  logic [CNT_W-1:0]  eff_count;

  // latched item
  logic [OP_W-1:0]    op_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [REQ_W-1:0]   req_q;
  logic [ALIGN_W-1:0] align_q;

  // pool state
  logic [LINK_W-1:0] head;
  logic [CNT_W-1:0]  used_count;
  logic [IDX_W-1:0]  sweep_idx;
  logic [CNT_W-1:0]  sweep_n;
  logic [31:0]       sweep_succ;
  logic [LINK_W-1:0] sweep_link;
  logic [PROD_W-1:0] prod_q;

  // result being built
  logic [ADDR_W-1:0]   res_addr;
  logic                res_null;
  logic [ORIG_W-1:0]   res_orig;
  logic [STATUS_W-1:0] res_status;

  // divider
  logic [ADDR_W-1:0] div_quo;
  logic [SIZE_W-1:0] div_rem;
  logic              div_done;
  logic [IDX_W-1:0]  q_idx;

  // memories
  logic              link_we;
  logic [IDX_W-1:0]  link_waddr;
  logic [LINK_W-1:0] link_wdata;
  logic [LINK_W-1:0] link_rdata;
  logic [CLASS_W-1:0] class_rdata;

  always_comb begin
    eff_size = (element_size < fbpa_pkg::MIN_ELEMENT_SIZE) ? fbpa_pkg::MIN_ELEMENT_SIZE
                                                           : element_size;
    if (element_count == '0) begin
      eff_count = CNT_W'(1);
    end else if (32'(element_count) > 32'(MAX_BLOCKS)) begin
      eff_count = CNT_W'(MAX_BLOCKS);
    end else begin
      eff_count = element_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arena_base    <= fbpa_pkg::RST_ARENA_BASE;
      element_size  <= fbpa_pkg::RST_ELEMENT_SIZE;
      element_count <= fbpa_pkg::RST_ELEMENT_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fbpa_pkg::REG_ARENA_BASE:    arena_base    <= cfg_data[ADDR_W-1:0];
        fbpa_pkg::REG_ELEMENT_SIZE:  element_size  <= cfg_data[SIZE_W-1:0];
        fbpa_pkg::REG_ELEMENT_COUNT: element_count <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // item and result registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q       <= in_op;
      addr_q     <= in_addr;
      req_q      <= in_req;
      align_q    <= in_align;
      res_addr   <= '0;
      res_null   <= 1'b0;
      res_orig   <= '0;
      res_status <= fbpa_pkg::ST_OK;
    end else begin
      if (cmd.set_status) begin
        res_status <= cmd.status_code;
      end
      if (cmd.set_null) begin
        res_null <= 1'b1;
      end
      if (cmd.set_realloc) begin
        res_addr <= addr_q;
      end
      if (cmd.pop) begin
        res_addr <= arena_base + ADDR_W'(prod_q);
      end
      if (cmd.set_orig) begin
        res_orig <= fbpa_pkg::decode_class(class_rdata);
      end
    end
    if (cmd.mul) begin
      prod_q <= PROD_W'(head[IDX_W-1:0]) * PROD_W'(eff_size);
    end
  end

  // successor link written by the relink sweep
  assign sweep_succ = 32'(sweep_idx) + 32'd1;
  assign sweep_link = (sweep_succ < 32'(sweep_n)) ? {1'b0, sweep_succ[IDX_W-1:0]} : LINK_NULL;

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      used_count <= '0;
      sweep_idx  <= '0;
      sweep_n    <= RST_EFF_COUNT;
    end else if (cmd.sweep_init) begin
      head       <= '0;
      used_count <= '0;
      sweep_idx  <= '0;
      sweep_n    <= eff_count;
    end else begin
      if (cmd.sweep_step) begin
        sweep_idx <= sweep_idx + IDX_W'(1);
      end
      if (cmd.pop) begin
        head <= link_rdata;
        if (used_count != fbpa_pkg::COUNT_MAX) begin
          used_count <= used_count + CNT_W'(1);
        end
      end
      if (cmd.push) begin
        head <= {1'b0, q_idx};
        if (used_count != '0) begin
          used_count <= used_count - CNT_W'(1);
        end
      end
    end
  end

  fbpa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (addr_q - arena_base),
    .divisor   (eff_size),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign q_idx = div_quo[IDX_W-1:0];

  assign link_we    = cmd.sweep_step | cmd.push;
  assign link_waddr = cmd.push ? q_idx : sweep_idx;
  assign link_wdata = cmd.push ? head : sweep_link;

  fbpa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (cmd.link_rd),
    .raddr (head[IDX_W-1:0]),
    .rdata (link_rdata)
  );

  fbpa_ram #(
    .WIDTH (CLASS_W),
    .DEPTH (MAX_BLOCKS)
  ) u_class_ram (
    .clk   (clk),
    .we    (cmd.class_wr),
    .waddr (q_idx),
    .wdata (fbpa_pkg::encode_class(req_q)),
    .re    (cmd.class_rd),
    .raddr (q_idx),
    .rdata (class_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      out_addr   <= res_addr;
      out_null   <= res_null;
      out_orig   <= res_orig;
      out_status <= res_status;
      out_count  <= used_count;
      out_bsize  <= eff_size;
    end
  end

  always_comb begin
    sts.align_bad  = align_q > fbpa_pkg::ALIGN_MAX;
    sts.head_null  = head[IDX_W];
    sts.oversize   = req_q > REQ_W'(eff_size);
    sts.sweep_last = sweep_idx == IDX_W'(MAX_BLOCKS - 1);
    sts.div_done   = div_done;
    sts.addr_bad   = (div_rem != '0) || (div_quo >= 32'(eff_count));
    sts.out_free   = !out_valid || out_ready;
    sts.op         = op_q;
  end

endmodule

`default_nettype wire

### rtl/core/fbpa_ctrl.sv
// allocator controller: sequences each operation over the datapath
`default_nettype none

module fbpa_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire fbpa_pkg::fbpa_sts_t sts,
  output      fbpa_pkg::fbpa_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_DISPATCH,
    S_ALLOC_RD,
    S_DIV_WAIT,
    S_CLASS_RD,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   reply_pending;
  logic   reply_pending_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_SWEEP;
      reply_pending <= 1'b0;
    end else begin
      state         <= state_next;
      reply_pending <= reply_pending_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next         = state;
    reply_pending_next = reply_pending;
    cmd                = '0;
    unique case (state)
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_next         = reply_pending ? S_FINISH : S_IDLE;
          reply_pending_next = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_FINISH;
        unique case (sts.op)
          fbpa_pkg::OP_ALLOC: begin
            priority if (sts.align_bad) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = fbpa_pkg::ST_BAD_ALIGN;
            end else if (sts.head_null) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = fbpa_pkg::ST_EMPTY;
              cmd.set_null    = 1'b1;
            end else if (sts.oversize) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = fbpa_pkg::ST_TOO_LARGE;
            end else begin
              cmd.link_rd = 1'b1;
              cmd.mul     = 1'b1;
              state_next  = S_ALLOC_RD;
            end
          end
          fbpa_pkg::OP_FREE, fbpa_pkg::OP_SET, fbpa_pkg::OP_GET: begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV_WAIT;
          end
          fbpa_pkg::OP_REALLOC: begin
            if (sts.oversize) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = fbpa_pkg::ST_TOO_LARGE;
            end else begin
              cmd.set_realloc = 1'b1;
            end
          end
          fbpa_pkg::OP_REINIT: begin
            cmd.sweep_init     = 1'b1;
            reply_pending_next = 1'b1;
            state_next         = S_SWEEP;
          end
          default: ;
        endcase
      end
      S_ALLOC_RD: begin
        cmd.pop    = 1'b1;
        state_next = S_FINISH;
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          state_next = S_FINISH;
          if (sts.addr_bad) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = fbpa_pkg::ST_BAD_ADDR;
          end else begin
            unique case (sts.op)
              fbpa_pkg::OP_FREE: cmd.push     = 1'b1;
              fbpa_pkg::OP_SET:  cmd.class_wr = 1'b1;
              default: begin
                cmd.class_rd = 1'b1;
                state_next   = S_CLASS_RD;
              end
            endcase
          end
        end
      end
      S_CLASS_RD: begin
        cmd.set_orig = 1'b1;
        state_next   = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/fixed_block_pool_allocator_core.sv
// top level of the fixed block pool allocator: free-list pool with per-block size classes
//
// usage
//   s_axis carries one request item: tuser is the operation, tdata the operands.
//   m_axis returns exactly one result item for every request, in request order.
//   cfg writes arena_base (0), element_size (1) or element_count (2); other indexes
//   are ignored. cfg_ready is always high; write only while the block is idle.
// timing
//   one item at a time; s_axis_tready is high only while the controller waits for work
//   allocate: a valid request issues the link read and index multiply, then the pop loads the result
//   free and set: wait on the 32-step address-to-index divider; get then also reads the size class
//   reallocate and unused codes: result decided in the dispatch state
//   reinitialize: a sweep rewrites all MAX_BLOCKS link entries, one link entry per cycle
// reset
//   synchronous; then a relink pass over all MAX_BLOCKS entries rebuilds the free list
//   (block i to i+1, last to null) before the first item is taken; config writes are
//   taken during that pass
// stalls
//   the result sits in an output register; the next item is taken while it waits, and
//   only a finished second result waits for m_axis_tready
`default_nettype none

module fixed_block_pool_allocator_core #(
  parameter int MAX_BLOCKS = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // request items
  input  wire logic                                s_axis_tvalid,
  output      logic                                s_axis_tready,
  // block_address[31:0], request_size[47:32], alignment_code[50:48], zero fill
  input  wire logic [fbpa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // operation[2:0]
  input  wire logic [fbpa_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
  // result items
  output      logic                                m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // result_address[31:0], is_null[32], orig_size[38:33], status[41:39],
  // allocated_count[52:42], block_size[65:53], zero fill
  output      logic [fbpa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // configuration writes
  input  wire logic                                cfg_valid,
  output      logic                                cfg_ready,
  input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [fbpa_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int ADDR_W  = fbpa_pkg::ADDR_W;
  localparam int REQ_W   = fbpa_pkg::REQ_W;
  localparam int ALIGN_W = fbpa_pkg::ALIGN_W;
  localparam int USED_W  = ADDR_W + 1 + fbpa_pkg::ORIG_W + fbpa_pkg::STATUS_W
                           + fbpa_pkg::CNT_W + fbpa_pkg::SIZE_W;

  fbpa_pkg::fbpa_cmd_t cmd;
  fbpa_pkg::fbpa_sts_t sts;

  logic [ADDR_W-1:0]                out_addr;
  logic                             out_null;
  logic [fbpa_pkg::ORIG_W-1:0]      out_orig;
  logic [fbpa_pkg::STATUS_W-1:0]    out_status;
  logic [fbpa_pkg::CNT_W-1:0]       out_count;
  logic [fbpa_pkg::SIZE_W-1:0]      out_bsize;

  // registers are plain flops, a write always lands
  assign cfg_ready = 1'b1;

  fbpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fbpa_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid & cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_op      (s_axis_tuser),
    .in_addr    (s_axis_tdata[ADDR_W-1:0]),
    .in_req     (s_axis_tdata[ADDR_W +: REQ_W]),
    .in_align   (s_axis_tdata[ADDR_W + REQ_W +: ALIGN_W]),
    .out_ready  (m_axis_tready),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (m_axis_tvalid),
    .out_addr   (out_addr),
    .out_null   (out_null),
    .out_orig   (out_orig),
    .out_status (out_status),
    .out_count  (out_count),
    .out_bsize  (out_bsize)
  );

  // fields packed from the lowest bit up
  assign m_axis_tdata = {{(fbpa_pkg::OUT_TDATA_W - USED_W){1'b0}},
                         out_bsize, out_count, out_status, out_orig, out_null, out_addr};

  // one item in flight: ready must drop right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while another is in progress");

  // null result only with the empty-pool status and vice versa
  a_null_matches_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_null == (out_status == fbpa_pkg::ST_EMPTY)))
    else $error("is_null disagrees with status");

  // an error leaves address and size class fields at zero
  a_error_zero_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (out_status != fbpa_pkg::ST_OK) |-> (out_addr == '0) && (out_orig == '0))
    else $error("error result carries a nonzero address or size");

endmodule

`default_nettype wire

### sim/tb_fixed_block_pool_allocator_core.sv
// testbench for the fixed block pool allocator core, checked against a behavioral pool model
module tb_fixed_block_pool_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import fbpa_pkg::*;

  localparam int POOL_DEPTH      = 1024;
  localparam int LINK_END        = -1;     // end of the free list
  localparam int WATCHDOG_LIMIT  = 12000;  // cycles with no handshake anywhere
  localparam int PHASES          = 12;
  localparam int PHASE_ITEMS     = 140;

  // operation codes the block treats as no-ops
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
  // register index the block ignores
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [ADDR_W-1:0]  addr;
    logic [REQ_W-1:0]   size;
    logic [ALIGN_W-1:0] align;
  } pool_request_t;

  typedef struct {
    logic [ADDR_W-1:0]   addr;
    logic                is_null;
    logic [ORIG_W-1:0]   orig;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    count;
    logic [SIZE_W-1:0]   bsize;
  } pool_result_t;

  // one request plus, where it is obvious, the result typed in by hand
  typedef struct {
    pool_request_t req;
    bit            typed;
    pool_result_t  want;
  } planned_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  fixed_block_pool_allocator_core #(
    .MAX_BLOCKS(POOL_DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // pool model: registers, free list, per-block size classes
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0] arena_reg;
  logic [SIZE_W-1:0] size_reg;
  logic [CNT_W-1:0]  count_reg;

  int                pool_link [POOL_DEPTH];
  int                free_head;
  int unsigned       live_count;
  logic [ORIG_W-1:0] class_bytes [POOL_DEPTH];  // stored as decoded byte size
  bit                class_known [POOL_DEPTH];  // size class written at least once
  int unsigned       known_slots [$];           // indexes with a written size class

  // addresses handed out and not yet freed, used to build sensible frees
  logic [ADDR_W-1:0] live_blocks [$];

  pool_result_t      pending_results [$];
  int                mismatch_count = 0;
  int                gap_pct   = 0;             // chance of a sender gap per item
  int                stall_pct = 0;             // chance of a receiver stall per cycle
  int                take_wait = 0;
  int                idle_cycles = 0;

  function automatic int unsigned span_bytes();
    return (size_reg < MIN_ELEMENT_SIZE) ? MIN_ELEMENT_SIZE : size_reg;
  endfunction

  function automatic int unsigned span_blocks();
    if (count_reg == 0) return 1;
    if (count_reg > POOL_DEPTH) return POOL_DEPTH;
    return count_reg;
  endfunction

  function automatic logic [ADDR_W-1:0] block_addr(input int unsigned idx);
    return arena_reg + ADDR_W'(idx * span_bytes());
  endfunction

  // address to block index; false for misaligned or out-of-pool addresses
  function automatic bit locate_block(input logic [ADDR_W-1:0] addr, output int unsigned idx);
    logic [ADDR_W-1:0] offset;
    int unsigned sz;
    offset = addr - arena_reg;
    sz = span_bytes();
    idx = offset / sz;
    return (offset % sz == 0) && (idx < span_blocks());
  endfunction

  // chain blocks in order, last one terminates the list
  function automatic void relink_pool();
    int unsigned n;
    n = span_blocks();
    for (int i = 0; i < POOL_DEPTH; i++) begin
      pool_link[i] = (i + 1 < n) ? i + 1 : LINK_END;
    end
    free_head  = 0;
    live_count = 0;
  endfunction

  function automatic pool_result_t predict_pool_result(input pool_request_t r);
    pool_result_t res;
    int unsigned sz;
    int unsigned idx;
    sz = span_bytes();
    res.addr    = '0;
    res.is_null = 1'b0;
    res.orig    = '0;
    res.status  = ST_OK;
    case (r.op)
      OP_ALLOC: begin
        // alignment is checked first, then emptiness, then size
        if (r.align > ALIGN_MAX) begin
          res.status = ST_BAD_ALIGN;
        end else if (free_head == LINK_END) begin
          res.is_null = 1'b1;
          res.status  = ST_EMPTY;
        end else if (r.size > sz) begin
          res.status = ST_TOO_LARGE;
        end else begin
          idx       = free_head;
          res.addr  = arena_reg + ADDR_W'(idx * sz);
          free_head = pool_link[idx];
          if (live_count < COUNT_MAX) live_count++;
          live_blocks.push_back(res.addr);
        end
      end
      OP_FREE: begin
        // double frees are pushed again, the count floors at zero
        if (!locate_block(r.addr, idx)) begin
          res.status = ST_BAD_ADDR;
        end else begin
          pool_link[idx] = free_head;
          free_head      = idx;
          if (live_count > 0) live_count--;
        end
      end
      OP_REALLOC: begin
        // address is passed through unchecked
        if (r.size > sz) res.status = ST_TOO_LARGE;
        else res.addr = r.addr;
      end
      OP_SET: begin
        if (!locate_block(r.addr, idx)) begin
          res.status = ST_BAD_ADDR;
        end else begin
          class_bytes[idx] = (r.size <= 4)  ? 6'd4  :
                             (r.size <= 8)  ? 6'd8  :
                             (r.size <= 32) ? 6'd32 :
                             (r.size <= 48) ? 6'd48 : 6'd0;
          if (!class_known[idx]) known_slots.push_back(idx);
          class_known[idx] = 1'b1;
        end
      end
      OP_GET: begin
        if (!locate_block(r.addr, idx)) res.status = ST_BAD_ADDR;
        else res.orig = class_bytes[idx];
      end
      OP_REINIT: begin
        relink_pool();
        live_blocks.delete();
      end
      default: ;
    endcase
    res.count = CNT_W'(live_count);
    res.bsize = SIZE_W'(sz);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic planned_item_t row(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                                        input logic [REQ_W-1:0] size,
                                        input logic [ALIGN_W-1:0] align, input bit typed,
                                        input logic [ADDR_W-1:0] want_addr,
                                        input logic [STATUS_W-1:0] want_status,
                                        input logic [CNT_W-1:0] want_count,
                                        input logic [ORIG_W-1:0] want_orig);
    planned_item_t p;
    p.req.op       = op;
    p.req.addr     = addr;
    p.req.size     = size;
    p.req.align    = align;
    p.typed        = typed;
    p.want.addr    = want_addr;
    p.want.is_null = 1'b0;
    p.want.orig    = want_orig;
    p.want.status  = want_status;
    p.want.count   = want_count;
    p.want.bsize   = RST_ELEMENT_SIZE;
    return p;
  endfunction

  // mostly fits the block, sometimes just too large, sometimes anything
  function automatic logic [REQ_W-1:0] pick_size(input int unsigned sz);
    case ($urandom_range(0, 9))
      0:       return REQ_W'($urandom);
      1:       return REQ_W'(sz + $urandom_range(1, 8));
      default: return REQ_W'($urandom_range(0, sz));
    endcase
  endfunction

  // misaligned, just past the pool, or fully random
  function automatic logic [ADDR_W-1:0] pick_bad_addr();
    int unsigned sz;
    int unsigned cnt;
    sz  = span_bytes();
    cnt = span_blocks();
    case ($urandom_range(0, 2))
      0:       return block_addr($urandom_range(0, cnt - 1)) + $urandom_range(1, sz - 1);
      1:       return block_addr(cnt + $urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  // mostly well-formed traffic: frees of live blocks, sets on pool blocks,
  // gets of blocks whose size class is known
  function automatic pool_request_t make_random_request();
    pool_request_t r;
    int unsigned sz;
    int unsigned cnt;
    int unsigned pick;
    int unsigned roll;
    int unsigned slot;
    int unsigned idx;
    sz      = span_bytes();
    cnt     = span_blocks();
    pick    = $urandom_range(0, 99);
    roll    = $urandom_range(0, 99);
    r.op    = OP_ALLOC;
    r.addr  = $urandom;
    r.size  = pick_size(sz);
    r.align = ($urandom_range(0, 19) == 0) ? ALIGN_W'($urandom_range(3, 7))
                                           : ALIGN_W'($urandom_range(0, 2));
    if (pick < 32) begin
      r.op = OP_ALLOC;
    end else if (pick < 58) begin
      r.op = OP_FREE;
      if (roll < 70 && live_blocks.size() != 0) begin
        slot   = $urandom_range(0, live_blocks.size() - 1);
        r.addr = live_blocks[slot];
        live_blocks.delete(slot);
      end else if (roll < 85) begin
        r.addr = block_addr($urandom_range(0, cnt - 1));
      end else begin
        r.addr = pick_bad_addr();
      end
    end else if (pick < 66) begin
      r.op = OP_REALLOC;
    end else if (pick < 80) begin
      r.op   = OP_SET;
      r.addr = (roll < 10) ? pick_bad_addr() : block_addr($urandom_range(0, cnt - 1));
      r.size = (roll % 4 == 0) ? REQ_W'($urandom) : REQ_W'($urandom_range(0, 64));
    end else if (pick < 94) begin
      r.op = OP_GET;
      if (known_slots.size() != 0 && roll >= 10) begin
        r.addr = block_addr(known_slots[$urandom_range(0, known_slots.size() - 1)]);
      end else begin
        r.addr = pick_bad_addr();
      end
    end else if (pick < 97) begin
      r.op = OP_REINIT;
    end else begin
      r.op = roll[0] ? OP_SPARE_6 : OP_SPARE_7;
    end
    // a get may only read a size class that has been written
    if (r.op == OP_GET && locate_block(r.addr, idx) && !class_known[idx]) r.op = OP_SET;
    return r;
  endfunction

  // present one item, with an optional gap first; tvalid stays high afterwards
  task automatic send_request(input planned_item_t plan);
    pool_result_t want;
    int gap;
    if ($urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, plan.req.align, plan.req.size, plan.req.addr};
    s_axis_tuser  <= plan.req.op;
    do @(posedge clk); while (!s_axis_tready);
    want = predict_pool_result(plan.req);
    pending_results.push_back(plan.typed ? plan.want : want);
  endtask

  // stop sending and wait until every result has come back
  task automatic settle_pool();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ARENA_BASE:    arena_reg = value;
      REG_ELEMENT_SIZE:  size_reg  = value[SIZE_W-1:0];
      REG_ELEMENT_COUNT: count_reg = value[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name, input logic [ADDR_W-1:0] want,
                               input logic [ADDR_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall bursts, none when stall_pct is zero
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (take_wait != 0) begin
      take_wait = take_wait - 1;
    end else if (!m_axis_tready || $urandom_range(0, 99) >= stall_pct) begin
      m_axis_tready <= 1'b1;
    end else begin
      // burst of low cycles, held while take_wait counts down to zero
      m_axis_tready <= 1'b0;
      take_wait = $urandom_range(0, 7);
    end
  end

  // every accepted result is checked against the oldest expectation
  always @(posedge clk) begin : check_results
    pool_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result item expected none got %h", $time, m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        compare_field("result_address",  want.addr,    m_axis_tdata[31:0]);
        compare_field("is_null",         want.is_null, m_axis_tdata[32]);
        compare_field("orig_size",       want.orig,    m_axis_tdata[38:33]);
        compare_field("status",          want.status,  m_axis_tdata[41:39]);
        compare_field("allocated_count", want.count,   m_axis_tdata[52:42]);
        compare_field("block_size",      want.bsize,   m_axis_tdata[65:53]);
        compare_field("zero fill",       '0,           m_axis_tdata[71:66]);
      end
    end
  end

  // watchdog: too long without any handshake means the block is stuck
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    planned_item_t     plan;
    planned_item_t     directed [$];
    logic [ADDR_W-1:0] base_val;
    logic [SIZE_W-1:0] size_val;
    logic [CNT_W-1:0]  count_val;
    bit                fresh_list;

    // model state after reset; size classes start out unknown
    arena_reg = RST_ARENA_BASE;
    size_reg  = RST_ELEMENT_SIZE;
    count_reg = RST_ELEMENT_COUNT;
    for (int i = 0; i < POOL_DEPTH; i++) begin
      class_bytes[i] = '0;
      class_known[i] = 1'b0;
    end
    relink_pool();
    gap_pct   = 20;
    stall_pct = 20;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part on the reset configuration: 16-byte blocks, 1024 of them
    directed.push_back(row(OP_ALLOC,   32'h0,         16,     0, 1, 32'h0,  ST_OK,        2'd1, 0));
    directed.push_back(row(OP_ALLOC,   32'hFFFF_FFFF, 0,      2, 1, 32'd16, ST_OK,        2'd2, 0));
    // alignment error wins over everything else
    directed.push_back(row(OP_ALLOC,   32'h0,         0,      7, 1, 32'h0,  ST_BAD_ALIGN, 2'd2, 0));
    directed.push_back(row(OP_ALLOC,   32'h0,         16'hFFFF, 3, 1, 32'h0, ST_BAD_ALIGN, 2'd2, 0));
    directed.push_back(row(OP_ALLOC,   32'h0,         17,     1, 1, 32'h0,  ST_TOO_LARGE, 2'd2, 0));
    // reallocate passes any address through, but still checks the size
    directed.push_back(row(OP_REALLOC, 32'hFFFF_FFFF, 16,     0, 1, 32'hFFFF_FFFF, ST_OK, 2'd2, 0));
    directed.push_back(row(OP_REALLOC, 32'h5,         17,     0, 1, 32'h0,  ST_TOO_LARGE, 2'd2, 0));
    // every size class, and the catch-all above 48 bytes
    directed.push_back(row(OP_SET,     32'h0,         0,      0, 1, 32'h0,  ST_OK,        2'd2, 0));
    directed.push_back(row(OP_GET,     32'h0,         0,      0, 1, 32'h0,  ST_OK,        2'd2, 4));
    directed.push_back(row(OP_SET,     32'd16,        5,      0, 1, 32'h0,  ST_OK,        2'd2, 0));
    directed.push_back(row(OP_GET,     32'd16,        0,      0, 1, 32'h0,  ST_OK,        2'd2, 8));
    directed.push_back(row(OP_SET,     32'd32,        32,     0, 1, 32'h0,  ST_OK,        2'd2, 0));
    directed.push_back(row(OP_GET,     32'd32,        0,      0, 1, 32'h0,  ST_OK,        2'd2, 32));
    directed.push_back(row(OP_SET,     32'd16368,     48,     0, 1, 32'h0,  ST_OK,        2'd2, 0));
    directed.push_back(row(OP_GET,     32'd16368,     0,      0, 1, 32'h0,  ST_OK,        2'd2, 48));
    directed.push_back(row(OP_SET,     32'd16368,     49,     0, 1, 32'h0,  ST_OK,        2'd2, 0));
    directed.push_back(row(OP_GET,     32'd16368,     0,      0, 1, 32'h0,  ST_OK,        2'd2, 0));
    // one past the last block, misaligned, and wrapped below the base
    directed.push_back(row(OP_GET,     32'd16384,     0,      0, 1, 32'h0,  ST_BAD_ADDR,  2'd2, 0));
    directed.push_back(row(OP_SET,     32'd17,        0,      0, 1, 32'h0,  ST_BAD_ADDR,  2'd2, 0));
    directed.push_back(row(OP_FREE,    32'hFFFF_FFF0, 0,      0, 1, 32'h0,  ST_BAD_ADDR,  2'd2, 0));
    directed.push_back(row(OP_FREE,    32'd16,        0,      0, 1, 32'h0,  ST_OK,        2'd1, 0));
    directed.push_back(row(OP_FREE,    32'h0,         0,      0, 1, 32'h0,  ST_OK,        2'd0, 0));
    // double free with the count already at zero
    directed.push_back(row(OP_FREE,    32'h0,         0,      0, 1, 32'h0,  ST_OK,        2'd0, 0));
    directed.push_back(row(OP_ALLOC,   32'h0,         4,      0, 0, 32'h0,  ST_OK,        2'd0, 0));
    directed.push_back(row(OP_SPARE_6, 32'hFFFF_FFFF, 16'hFFFF, 7, 0, 32'h0, ST_OK,       2'd0, 0));
    directed.push_back(row(OP_REINIT,  32'h0,         0,      0, 1, 32'h0,  ST_OK,        2'd0, 0));
    directed.push_back(row(OP_ALLOC,   32'h0,         16,     0, 1, 32'h0,  ST_OK,        2'd1, 0));
    foreach (directed[i]) send_request(directed[i]);

    // random phases, each on its own configuration
    for (int p = 0; p < PHASES; p++) begin
      settle_pool();
      fresh_list = 1'b1;
      case (p)
        0: begin base_val = 32'h0;         size_val = 13'd4;    count_val = 11'd1;    end
        1: begin base_val = 32'hFFFF_FFF0; size_val = 13'd4096; count_val = 11'd1024; end
        2: begin base_val = $urandom;      size_val = 13'd24;   count_val = 11'd7;    end
        // below-minimum size and zero count, both clamped by the block
        3: begin base_val = 32'h0000_1000; size_val = 13'd2;    count_val = 11'd0;    end
        4: begin base_val = $urandom;      size_val = 13'h1FFF; count_val = 11'h7FF;  end
        // no relink here: the old free list runs on under new geometry
        5: begin
          base_val   = $urandom;
          size_val   = 13'd33;
          count_val  = 11'd16;
          fresh_list = 1'b0;
        end
        default: begin
          base_val   = $urandom;
          size_val   = ($urandom_range(0, 9) < 7) ? SIZE_W'($urandom_range(4, 64))
                                                  : SIZE_W'($urandom_range(4, 4096));
          count_val  = ($urandom_range(0, 9) < 7) ? CNT_W'($urandom_range(1, 32))
                                                  : CNT_W'($urandom_range(1, 1024));
          fresh_list = ($urandom_range(0, 4) != 0);
        end
      endcase
      write_reg(REG_ELEMENT_SIZE,  CFG_DATA_W'(size_val));
      write_reg(REG_ARENA_BASE,    base_val);
      write_reg(REG_ELEMENT_COUNT, CFG_DATA_W'(count_val));
      if (p == 5) write_reg(REG_SPARE, $urandom);
      @(negedge clk);
      cfg_valid <= 1'b0;
      live_blocks.delete();

      // the last phase runs without any idling
      if (p == PHASES - 1) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       begin gap_pct = 0;  stall_pct = 10; end
          1:       begin gap_pct = 10; stall_pct = 0;  end
          default: begin gap_pct = 35; stall_pct = 35; end
        endcase
      end

      if (fresh_list) send_request(row(OP_REINIT, $urandom, REQ_W'($urandom),
                                       ALIGN_W'($urandom), 0, 32'h0, ST_OK, 2'd0, 0));
      repeat (PHASE_ITEMS) begin
        plan.req   = make_random_request();
        plan.typed = 1'b0;
        send_request(plan);
      end
    end

    settle_pool();
    repeat (64) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
